/* rtl/core/sample_packetizer_ring_macros.svh */
// Assertion macros shared by the sample packetizer ring RTL.
`ifndef SAMPLE_PACKETIZER_RING_MACROS_SVH
`define SAMPLE_PACKETIZER_RING_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge out of reset.
`define SPR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sample_packetizer_ring: check failed");
// Next-cycle implication, checked on every rising clock edge out of reset.
`define SPR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sample_packetizer_ring: check failed");
`else
`define SPR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SPR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/spr_pkg.sv */
// Package with constants, types and helpers of the sample packetizer ring.
`default_nettype none
package spr_pkg;

    localparam int SAMPLES_PER_PACKET = 512;
    localparam int PACKET_SLOTS       = 8;
    localparam int SAMPLE_BITS        = 12;
    localparam int HDR_WORDS          = 10;

    localparam int SLOT_W    = $clog2(PACKET_SLOTS);
    localparam int FPOS_W    = (SAMPLES_PER_PACKET > 1) ? $clog2(SAMPLES_PER_PACKET) : 1;
    localparam int DPOS_W    = $clog2(HDR_WORDS + SAMPLES_PER_PACKET);
    localparam int HIDX_W    = $clog2(HDR_WORDS);
    localparam int SADDR_W   = SLOT_W + FPOS_W;
    localparam int SMEM_DEPTH = PACKET_SLOTS * (2 ** FPOS_W);

    localparam logic [31:0] TAG_A     = 32'h5049434F;
    localparam logic [31:0] TAG_B     = 32'h41444321;
    localparam logic [15:0] HALF_MASK = 16'hFFFF;

    // Input kinds carried in tuser.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Header halfword positions.
    localparam logic [HIDX_W-1:0] HW_TAG_A_LO = HIDX_W'(0);
    localparam logic [HIDX_W-1:0] HW_TAG_A_HI = HIDX_W'(1);
    localparam logic [HIDX_W-1:0] HW_TAG_B_LO = HIDX_W'(2);
    localparam logic [HIDX_W-1:0] HW_TAG_B_HI = HIDX_W'(3);
    localparam logic [HIDX_W-1:0] HW_SEQ_LO   = HIDX_W'(4);
    localparam logic [HIDX_W-1:0] HW_SEQ_HI   = HIDX_W'(5);
    localparam logic [HIDX_W-1:0] HW_DROP_LO  = HIDX_W'(6);
    localparam logic [HIDX_W-1:0] HW_DROP_HI  = HIDX_W'(7);
    localparam logic [HIDX_W-1:0] HW_LENGTH   = HIDX_W'(8);

    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] drops;
        logic [15:0] sum;
    } hdr_t;

    typedef enum logic [1:0] {
        WK_NONE,
        WK_HDR,
        WK_SAMPLE
    } word_kind_t;

    // Read transaction in flight between memory read and output register.
    typedef struct packed {
        word_kind_t        kind;
        logic [HIDX_W-1:0] hidx;
        logic              last;
    } rd_info_t;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(PACKET_SLOTS - 1))
        begin
            r = '0;
        end
        else
        begin
            r = s + SLOT_W'(1);
        end
        return r;
    endfunction

    function automatic logic [15:0] header_word(input hdr_t h, input logic [HIDX_W-1:0] i);
        logic [15:0] w;
        case (i)
            HW_TAG_A_LO: w = TAG_A[15:0];
            HW_TAG_A_HI: w = TAG_A[31:16];
            HW_TAG_B_LO: w = TAG_B[15:0];
            HW_TAG_B_HI: w = TAG_B[31:16];
            HW_SEQ_LO:   w = h.seq[15:0];
            HW_SEQ_HI:   w = h.seq[31:16];
            HW_DROP_LO:  w = h.drops[15:0];
            HW_DROP_HI:  w = h.drops[31:16];
            HW_LENGTH:   w = 16'(SAMPLES_PER_PACKET) & HALF_MASK;
            default:     w = h.sum;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/sample_packetizer_ring.sv */
// Top level of the sample packetizer ring: capture, slot ring memories and host read-out.
//
// Converter samples (tuser = 0) are written into a ring of packet slots held in one
// synchronous sample memory; at each packet end the sequence number, running drop count
// and 16-bit wrapping checksum go into a small header memory and the slot is marked
// ready. When the next slot is still ready, the following packet's worth of samples is
// dropped and counted, and the check repeats at the end of that run. Read requests
// (tuser = 1) return one halfword each: ten little-endian header halfwords, then the
// samples, with tlast on the final sample; a request with nothing to give returns a
// transaction with tuser (word valid) low and zero data. A new packet starts draining
// only while host_connected is high; once started it runs to its end. The block takes
// one transaction per clock on the input and gives one per clock on the output while
// m_axis_tready does not hold the output; each transaction touches at most one word of
// each memory, and a result passes through the synchronous memory read, then the output register. The
// memories need no clearing pass after reset: only slot ready flags are cleared.
`default_nettype none
module sample_packetizer_ring (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [11:0] sample_value, [12] host_connected
    input  wire logic        s_axis_tuser,   // [0] opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] out_word
    output logic             m_axis_tuser,   // [0] word_valid
    output logic             m_axis_tlast    // last_word
);

`include "sample_packetizer_ring_macros.svh"

    // Memories: sample ring and per-slot headers.
    logic [spr_pkg::SAMPLE_BITS-1:0] sample_mem [spr_pkg::SMEM_DEPTH];
    spr_pkg::hdr_t                   hdr_mem    [spr_pkg::PACKET_SLOTS];

    // Control state.
    logic [spr_pkg::PACKET_SLOTS-1:0] slot_ready_reg, slot_ready_next;
    logic [spr_pkg::SLOT_W-1:0]       fill_slot_reg, fill_slot_next;
    logic [spr_pkg::SLOT_W-1:0]       drain_slot_reg, drain_slot_next;
    logic [spr_pkg::FPOS_W-1:0]       fill_pos_reg, fill_pos_next;
    logic [15:0]                      sum_reg, sum_next;
    logic [31:0]                      packet_cnt_reg, packet_cnt_next;
    logic [31:0]                      drop_cnt_reg, drop_cnt_next;
    logic                             discarding_reg, discarding_next;
    logic [spr_pkg::DPOS_W-1:0]       drain_pos_reg, drain_pos_next;
    logic                             draining_reg, draining_next;

    // Read stage and output register.
    logic                            p_valid_reg;
    spr_pkg::rd_info_t               p_info_reg, p_info_next;
    logic [spr_pkg::SAMPLE_BITS-1:0] smem_rd_reg;
    spr_pkg::hdr_t                   hmem_rd_reg;
    logic                            o_valid_reg;
    logic [15:0]                     o_data_reg, o_data_next;
    logic                            o_user_reg;
    logic                            o_last_reg;

    // Memory access requests.
    logic                            smem_we;
    logic [spr_pkg::SADDR_W-1:0]     smem_waddr;
    logic [spr_pkg::SADDR_W-1:0]     smem_raddr;
    logic                            hmem_we;
    spr_pkg::hdr_t                   hmem_wdata;

    logic                            in_fire;
    logic                            smp_fire;
    logic                            rd_fire;
    logic                            p_adv;
    logic [spr_pkg::SAMPLE_BITS-1:0] sample_in;
    logic                            conn_in;
    logic [15:0]                     sum_add;
    logic [spr_pkg::DPOS_W-1:0]      pos;
    logic [spr_pkg::DPOS_W-1:0]      k_full;
    logic [spr_pkg::FPOS_W-1:0]      k;
    logic                            is_hdr;
    logic                            is_last;

    // Advance the read stage when the output register is empty or being taken;
    // take a new transaction whenever the read stage will have room.
    assign p_adv         = p_valid_reg && (!o_valid_reg || m_axis_tready);
    assign s_axis_tready = !p_valid_reg || p_adv;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign smp_fire      = in_fire && (s_axis_tuser == spr_pkg::OP_SAMPLE);
    assign rd_fire       = in_fire && (s_axis_tuser == spr_pkg::OP_READ);
    assign sample_in     = s_axis_tdata[spr_pkg::SAMPLE_BITS-1:0];
    assign conn_in       = s_axis_tdata[12];
    assign sum_add       = sum_reg + 16'(sample_in);

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = o_data_reg;
    assign m_axis_tuser  = o_user_reg;
    assign m_axis_tlast  = o_last_reg;

    // Capture and drain bookkeeping; all of it lives in this one block.
    always_comb
    begin
        slot_ready_next = slot_ready_reg;
        fill_slot_next  = fill_slot_reg;
        drain_slot_next = drain_slot_reg;
        fill_pos_next   = fill_pos_reg;
        sum_next        = sum_reg;
        packet_cnt_next = packet_cnt_reg;
        drop_cnt_next   = drop_cnt_reg;
        discarding_next = discarding_reg;
        drain_pos_next  = drain_pos_reg;
        draining_next   = draining_reg;
        smem_we         = 1'b0;
        smem_waddr      = {fill_slot_reg, fill_pos_reg};
        hmem_we         = 1'b0;
        hmem_wdata      = '{seq: packet_cnt_reg, drops: drop_cnt_reg, sum: sum_add};
        p_info_next     = '{kind: spr_pkg::WK_NONE, hidx: '0, last: 1'b0};

        pos     = draining_reg ? drain_pos_reg : '0;
        is_hdr  = pos < spr_pkg::DPOS_W'(spr_pkg::HDR_WORDS);
        k_full  = pos - spr_pkg::DPOS_W'(spr_pkg::HDR_WORDS);
        k       = k_full[spr_pkg::FPOS_W-1:0];
        is_last = !is_hdr && (k == spr_pkg::FPOS_W'(spr_pkg::SAMPLES_PER_PACKET - 1));
        smem_raddr = {drain_slot_reg, k};

        if (smp_fire)
        begin
            // Store and sum unless the run is being dropped.
            if (!discarding_reg)
            begin
                smem_we  = 1'b1;
                sum_next = sum_add;
            end
            fill_pos_next = fill_pos_reg + spr_pkg::FPOS_W'(1);
            if (fill_pos_reg == spr_pkg::FPOS_W'(spr_pkg::SAMPLES_PER_PACKET - 1))
            begin
                fill_pos_next = '0;
                sum_next      = '0;
                if (!discarding_reg)
                begin
                    // Close the packet: header, ready mark, advance the ring.
                    hmem_we                        = 1'b1;
                    packet_cnt_next                = packet_cnt_reg + 32'd1;
                    slot_ready_next[fill_slot_reg] = 1'b1;
                    fill_slot_next                 = spr_pkg::next_slot(fill_slot_reg);
                end
                // Drop the next run if its slot is still occupied.
                if (slot_ready_reg[fill_slot_next])
                begin
                    drop_cnt_next   = drop_cnt_reg + 32'd1;
                    discarding_next = 1'b1;
                end
                else
                begin
                    discarding_next = 1'b0;
                end
            end
        end

        if (rd_fire && (draining_reg || (slot_ready_reg[drain_slot_reg] && conn_in)))
        begin
            p_info_next.kind = is_hdr ? spr_pkg::WK_HDR : spr_pkg::WK_SAMPLE;
            p_info_next.hidx = pos[spr_pkg::HIDX_W-1:0];
            p_info_next.last = is_last;
            if (is_last)
            begin
                slot_ready_next[drain_slot_reg] = 1'b0;
                drain_slot_next                 = spr_pkg::next_slot(drain_slot_reg);
                draining_next                   = 1'b0;
                drain_pos_next                  = '0;
            end
            else
            begin
                draining_next  = 1'b1;
                drain_pos_next = pos + spr_pkg::DPOS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_ready_reg <= '0;
            fill_slot_reg  <= '0;
            drain_slot_reg <= '0;
            fill_pos_reg   <= '0;
            sum_reg        <= '0;
            packet_cnt_reg <= '0;
            drop_cnt_reg   <= '0;
            discarding_reg <= 1'b0;
            drain_pos_reg  <= '0;
            draining_reg   <= 1'b0;
        end
        else
        begin
            slot_ready_reg <= slot_ready_next;
            fill_slot_reg  <= fill_slot_next;
            drain_slot_reg <= drain_slot_next;
            fill_pos_reg   <= fill_pos_next;
            sum_reg        <= sum_next;
            packet_cnt_reg <= packet_cnt_next;
            drop_cnt_reg   <= drop_cnt_next;
            discarding_reg <= discarding_next;
            drain_pos_reg  <= drain_pos_next;
            draining_reg   <= draining_next;
        end
    end

    // Sample memory: one write port for capture, one registered read port for drain.
    always_ff @(posedge clk)
    begin
        if (smem_we)
        begin
            sample_mem[smem_waddr] <= sample_in;
        end
        if (rd_fire)
        begin
            smem_rd_reg <= sample_mem[smem_raddr];
        end
    end

    // Header memory: written at packet close, read for every read request.
    always_ff @(posedge clk)
    begin
        if (hmem_we)
        begin
            hdr_mem[fill_slot_reg] <= hmem_wdata;
        end
        if (rd_fire)
        begin
            hmem_rd_reg <= hdr_mem[drain_slot_reg];
        end
    end

    // Read stage valid and output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_fire)
            begin
                p_valid_reg <= 1'b1;
            end
            else if (p_adv)
            begin
                p_valid_reg <= 1'b0;
            end
            if (p_adv)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // Select the halfword from the memory data that just came back.
    always_comb
    begin
        case (p_info_reg.kind)
            spr_pkg::WK_HDR:    o_data_next = spr_pkg::header_word(hmem_rd_reg, p_info_reg.hidx);
            spr_pkg::WK_SAMPLE: o_data_next = 16'(smem_rd_reg);
            default:            o_data_next = '0;
        endcase
    end

    // Hold the read info for the memory data, then load the output register.
    always_ff @(posedge clk)
    begin
        if (rd_fire)
        begin
            p_info_reg <= p_info_next;
        end
        if (p_adv)
        begin
            o_data_reg <= o_data_next;
            o_user_reg <= (p_info_reg.kind != spr_pkg::WK_NONE);
            o_last_reg <= p_info_reg.last;
        end
    end

    // Unless the run is being dropped, the slot being filled is never one still waiting to be read.
    `SPR_ASSERT_IMP(a_fill_slot_free, clk, rst_n, !discarding_reg, !slot_ready_reg[fill_slot_reg])
    // A packet under read-out keeps its ready mark until its last halfword.
    `SPR_ASSERT_IMP(a_drain_slot_ready, clk, rst_n, draining_reg, slot_ready_reg[drain_slot_reg])
    // The end-of-packet mark only comes with a real halfword.
    `SPR_ASSERT_IMP(a_last_is_valid, clk, rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser)
    // Drops are only counted on a sample transaction.
    `SPR_ASSERT_NXT(a_drop_on_sample, clk, rst_n, !smp_fire, $stable(drop_cnt_reg))

endmodule
`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the sample packetizer ring: streamed samples and reads, scoreboarded.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spr_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;   // cycles with no transaction on either side
    localparam int SETTLE_CYCLES  = 8;      // settle time before the final check
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MASK = '1;

    // Receiver stall patterns.
    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_PERIODIC,
        RX_BURSTY
    } rx_mode_t;

    // One output halfword as the host sees it.
    typedef struct {
        logic        valid;
        logic [15:0] word;
        logic        last;
    } halfword_t;

    // Tracks capture and drain of the packet ring and checks every output halfword.
    class packet_scoreboard;
        logic [SAMPLE_BITS-1:0] store [PACKET_SLOTS * SAMPLES_PER_PACKET];
        bit                     ready [PACKET_SLOTS];
        hdr_t                   hdr [PACKET_SLOTS];
        logic [SLOT_W-1:0]      fill_slot;
        logic [SLOT_W-1:0]      drain_slot;
        int                     fill_pos;
        int                     drain_pos;
        logic [15:0]            running_sum;
        logic [31:0]            packet_count;
        logic [31:0]            drop_count;
        bit                     discarding;
        bit                     draining;
        halfword_t              expected_q [$];
        int                     failures;

        function new();
            foreach (ready[i])
                ready[i] = 1'b0;
            fill_slot    = '0;
            drain_slot   = '0;
            fill_pos     = 0;
            drain_pos    = 0;
            running_sum  = '0;
            packet_count = '0;
            drop_count   = '0;
            discarding   = 1'b0;
            draining     = 1'b0;
            failures     = 0;
        endfunction

        function logic [SLOT_W-1:0] step_slot(input logic [SLOT_W-1:0] s);
            return (s == SLOT_W'(PACKET_SLOTS - 1)) ? '0 : s + 1'b1;
        endfunction

        function logic [15:0] header_half(input hdr_t h, input int pos);
            logic [15:0] w;
            case (HIDX_W'(pos))
                HW_TAG_A_LO: w = TAG_A[15:0];
                HW_TAG_A_HI: w = TAG_A[31:16];
                HW_TAG_B_LO: w = TAG_B[15:0];
                HW_TAG_B_HI: w = TAG_B[31:16];
                HW_SEQ_LO:   w = h.seq[15:0];
                HW_SEQ_HI:   w = h.seq[31:16];
                HW_DROP_LO:  w = h.drops[15:0];
                HW_DROP_HI:  w = h.drops[31:16];
                HW_LENGTH:   w = 16'(SAMPLES_PER_PACKET);
                default:     w = h.sum;
            endcase
            return w;
        endfunction

        function void capture(input logic [11:0] value);
            logic [SAMPLE_BITS-1:0] v;
            v = value[SAMPLE_BITS-1:0] & SAMPLE_MASK;
            if (!discarding)
            begin
                store[int'(fill_slot) * SAMPLES_PER_PACKET + fill_pos] = v;
                running_sum = running_sum + 16'(v);
            end
            fill_pos++;
            if (fill_pos < SAMPLES_PER_PACKET)
                return;
            if (!discarding)
            begin
                hdr[fill_slot] = '{seq: packet_count, drops: drop_count, sum: running_sum};
                packet_count   = packet_count + 1'b1;
                ready[fill_slot] = 1'b1;
                fill_slot = step_slot(fill_slot);
            end
            fill_pos    = 0;
            running_sum = '0;
            discarding  = ready[fill_slot];
            if (discarding)
                drop_count = drop_count + 1'b1;
        endfunction

        // Note an accepted input transaction; reads queue the halfword they must return.
        function void note_input(input logic op, input logic [11:0] value, input logic conn);
            halfword_t r;
            int        k;
            if (op == OP_SAMPLE)
            begin
                capture(value);
                return;
            end
            r = '{valid: 1'b0, word: 16'h0000, last: 1'b0};
            if (!draining)
            begin
                if (!ready[drain_slot] || !conn)
                begin
                    expected_q.push_back(r);
                    return;
                end
                draining  = 1'b1;
                drain_pos = 0;
            end
            r.valid = 1'b1;
            if (drain_pos < HDR_WORDS)
            begin
                r.word = header_half(hdr[drain_slot], drain_pos);
            end
            else
            begin
                k      = drain_pos - HDR_WORDS;
                r.word = 16'(store[int'(drain_slot) * SAMPLES_PER_PACKET + k]);
                r.last = (k + 1 >= SAMPLES_PER_PACKET);
            end
            if (r.last)
            begin
                ready[drain_slot] = 1'b0;
                drain_slot = step_slot(drain_slot);
                draining   = 1'b0;
                drain_pos  = 0;
            end
            else
            begin
                drain_pos++;
            end
            expected_q.push_back(r);
        endfunction

        // Compare an accepted output transaction with the oldest queued halfword.
        function void check_result(input logic valid, input logic [15:0] word, input logic last);
            halfword_t e;
            if (expected_q.size() == 0)
            begin
                $error("out_word: no halfword expected, actual %h", word);
                failures++;
                return;
            end
            e = expected_q.pop_front();
            if (valid !== e.valid)
            begin
                $error("word_valid: expected %0b, actual %0b", e.valid, valid);
                failures++;
            end
            if (word !== e.word)
            begin
                $error("out_word: expected %h, actual %h", e.word, word);
                failures++;
            end
            if (last !== e.last)
            begin
                $error("last_word: expected %0b, actual %0b", e.last, last);
                failures++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // True while some packet is ready or part-way through its read-out.
        function bit has_packets();
            bit any;
            any = draining;
            foreach (ready[i])
                any |= ready[i];
            return any;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // [11:0] sample_value, [12] host_connected
    logic        s_axis_tuser = 1'b0;   // [0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [15:0] out_word
    logic        m_axis_tuser;          // [0] word_valid
    logic        m_axis_tlast;          // last_word

    packet_scoreboard sb = new();

    rx_mode_t rx_mode = RX_FREE;
    bit       tx_gaps = 1'b1;
    int       burst_left = 1;

    sample_packetizer_ring i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    // Receiver: update tready at the falling edge following the current stall pattern.
    int rx_tick = 0;
    int rx_hold = 0;
    always @(negedge clk)
    begin
        rx_tick++;
        case (rx_mode)
            RX_FREE:     m_axis_tready <= 1'b1;
            RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 99) < 70);
            RX_PERIODIC: m_axis_tready <= ((rx_tick % 5) < 3);
            default:
            begin
                // Hold tready low for a stretch, then open it for another stretch.
                if (rx_hold > 0)
                begin
                    rx_hold--;
                end
                else
                begin
                    m_axis_tready <= ~m_axis_tready;
                    rx_hold = m_axis_tready ? $urandom_range(1, 24) : $urandom_range(4, 40);
                end
            end
        endcase
    end

    // Monitor: sample both handshakes at the rising edge, feed the scoreboard, run the watchdog.
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            // Note the input first: a result never leaves in the cycle of its request.
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.note_input(s_axis_tuser, s_axis_tdata[11:0], s_axis_tdata[12]);
                idle_cycles = 0;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
                idle_cycles = 0;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Present one input transaction at the falling edge and hold it until accepted;
    // between bursts, when tx_gaps is set, drop tvalid for a random gap.
    task automatic drive_item(input logic op, input logic [11:0] value, input logic conn);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, conn, value};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        if (tx_gaps)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                burst_left = $urandom_range(1, 40);
            end
        end
    endtask

    function automatic logic [11:0] pick_sample();
        logic [11:0] v;
        case ($urandom_range(0, 7))
            0:       v = 12'h000;
            1:       v = 12'hFFF;
            default: v = 12'($urandom_range(0, 4095));
        endcase
        return v;
    endfunction

    // One random transaction: a sample with the given percentage, otherwise a read.
    task automatic drive_random(input int sample_pct, input int conn_pct);
        logic op;
        logic conn;
        op   = ($urandom_range(0, 99) < sample_pct) ? OP_SAMPLE : OP_READ;
        conn = ($urandom_range(0, 99) < conn_pct);
        drive_item(op, pick_sample(), conn);
    endtask

    // Drop tvalid and hold off until every queued halfword has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        int n;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reads with nothing ready (both link states), extreme samples, reads again.
        rx_mode = RX_FREE;
        drive_item(OP_READ, 12'h000, 1'b1);
        drive_item(OP_READ, 12'hFFF, 1'b0);
        drive_item(OP_SAMPLE, 12'h000, 1'b0);
        drive_item(OP_SAMPLE, 12'hFFF, 1'b1);
        drive_item(OP_SAMPLE, 12'h800, 1'b0);
        drive_item(OP_SAMPLE, 12'h001, 1'b1);
        drive_item(OP_SAMPLE, 12'hAAA, 1'b1);
        drive_item(OP_SAMPLE, 12'h555, 1'b0);
        drive_item(OP_SAMPLE, 12'h7FF, 1'b1);
        drive_item(OP_READ, 12'h000, 1'b1);
        drive_item(OP_READ, 12'h000, 1'b0);

        // Mostly samples: complete the first packet and start on the next one.
        rx_mode = RX_RANDOM;
        repeat (560) drive_random(95, 75);

        // Hold the sender until the output has caught up.
        wait_drained();

        // Mostly samples, reads with the link down while a packet waits: no new packet may start draining.
        rx_mode = RX_PERIODIC;
        repeat (60) drive_random(90, 0);

        // Read the ring empty while new samples trickle in; link drops mid-packet now and then.
        rx_mode = RX_BURSTY;
        n = 0;
        while (sb.has_packets() && n < 1500)
        begin
            drive_random(25, 85);
            n++;
        end
        drive_item(OP_READ, 12'h000, 1'b1);

        // A stretch without idling on either side.
        rx_mode = RX_FREE;
        tx_gaps = 1'b0;
        repeat (100) drive_random(55, 80);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl/core
rtl/core/spr_pkg.sv
rtl/core/sample_packetizer_ring.sv
test/tb.sv
